// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the cache tag check block.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ----- rtl/dmc_pkg.sv -----
// Shared types and constants of the direct-mapped cache tag check.
// No dependencies; used by dmc_tag_store and the top level.
package dmc_pkg;

  localparam int unsigned ADDR_W          = 32;
  localparam int unsigned MAX_LINES       = 64;
  localparam int unsigned LINE_W          = $clog2(MAX_LINES);
  localparam int unsigned OFFSET_W        = 4;
  localparam int unsigned INDEX_W         = 3;
  localparam int unsigned CFG_DATA_W      = 4;
  localparam int unsigned SHIFT_W         = 5;
  localparam logic [OFFSET_W-1:0] OFFSET_BITS_MAX   = 4'd12;
  localparam logic [INDEX_W-1:0]  INDEX_BITS_MAX    = 3'd6;
  localparam logic [OFFSET_W-1:0] OFFSET_BITS_RESET = 4'd4;
  localparam logic [INDEX_W-1:0]  INDEX_BITS_RESET  = 3'd3;

  typedef enum logic [0:0] {
    CFG_OFFSET_BITS = 1'b0,
    CFG_INDEX_BITS  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_HIT        = 2'd0,
    KIND_COMPULSORY = 2'd1,
    KIND_CONFLICT   = 2'd2
  } miss_kind_e;

  // Refill request into the tag store.
  typedef struct packed {
    logic              en;
    logic [LINE_W-1:0] idx;
    logic [ADDR_W-1:0] tag;
  } tag_wr_t;

  // Registered lookup data out of the tag store.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
  } tag_rd_t;

endpackage

// ----- rtl/dmc_tag_store.sv -----
// Tag memory with per-line valid bits for the direct-mapped cache tag check.
// Depends on dmc_pkg. One synchronous read port and one write port.
module dmc_tag_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [dmc_pkg::LINE_W-1:0]  rd_idx_i,
  output dmc_pkg::tag_rd_t            rd_o,
  input  dmc_pkg::tag_wr_t            wr_i
);
  import dmc_pkg::*;

  logic [ADDR_W-1:0]    tag_mem [MAX_LINES];
  logic [MAX_LINES-1:0] valid_q;
  logic [ADDR_W-1:0]    rd_tag_q;
  logic                 rd_valid_q;

  // Valid bits clear at reset, so lines never written read as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      tag_mem[wr_i.idx] <= wr_i.tag;
    end
    if (rd_en_i) begin
      rd_tag_q <= tag_mem[rd_idx_i];
    end
  end

  assign rd_o.valid = rd_valid_q;
  assign rd_o.tag   = rd_tag_q;

endmodule

// ----- rtl/direct_mapped_cache_tag_check.sv -----
// Top level of the direct-mapped cache tag check.
// Depends on dmc_pkg, dmc_tag_store and assert_macros.svh.
//
// Usage: a transaction is one 32-bit byte address on address_i, taken at a
// rising edge where start is high and busy is low. The address is split into
// offset, line index and tag using the offset_bits and index_bits registers
// (clamped to 12 and 6). The indexed line is looked up in a 64-entry tag
// memory; the result is a hit, a compulsory miss (line never filled) or a
// conflict miss (line holds another tag, which is evicted). Every miss
// refills the line with the new tag.
//
// Timing: the address indexes the tag memory at the accepting edge, the
// memory data is registered, and the compare, refill and counter update
// happen at the next edge. busy is high during that lookup, so a new
// transaction is accepted only after the previous lookup has completed.
// done_o rises with the result at the edge that completes the lookup.
// The receiver cannot stall; results are shown exactly once.
// Reset clears all valid bits at once (no clearing pass), both totals, and
// restores offset_bits to 4 and index_bits to 3. Configuration writes via
// cfg_we_i take effect at the next edge and should occur only while idle.
`include "assert_macros.svh"

module direct_mapped_cache_tag_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [dmc_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  // Command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [dmc_pkg::ADDR_W-1:0]      address_i,
  // Result channel
  output logic                            done_o,
  output logic                            hit_o,
  output logic [1:0]                      miss_kind_o,
  output logic                            evicted_o,
  output logic [dmc_pkg::LINE_W-1:0]      line_index_o,
  output logic [dmc_pkg::ADDR_W-1:0]      tag_value_o,
  output logic [dmc_pkg::ADDR_W-1:0]      hit_total_o,
  output logic [dmc_pkg::ADDR_W-1:0]      miss_total_o
);
  import dmc_pkg::*;

  // Configuration registers.
  logic [OFFSET_W-1:0] offset_bits_q;
  logic [INDEX_W-1:0]  index_bits_q;

  // Lookup stage: the transaction waiting for tag memory data.
  logic                busy_q;
  logic [LINE_W-1:0]   idx_q;
  logic [ADDR_W-1:0]   tag_q;

  // Result registers and running totals.
  logic                done_q;
  logic                hit_q;
  miss_kind_e          kind_q;
  logic                evicted_q;
  logic [ADDR_W-1:0]   hit_cnt_q;
  logic [ADDR_W-1:0]   miss_cnt_q;
  logic [LINE_W-1:0]   res_idx_q;
  logic [ADDR_W-1:0]   res_tag_q;

  logic                accept;
  logic [OFFSET_W-1:0] ob_eff;
  logic [INDEX_W-1:0]  ib_eff;
  logic [SHIFT_W-1:0]  tag_shift;
  logic [ADDR_W-1:0]   addr_sh;
  logic [LINE_W-1:0]   idx_mask;
  logic [LINE_W-1:0]   idx_d;
  logic [ADDR_W-1:0]   tag_d;

  tag_rd_t             rd;
  tag_wr_t             wr;
  logic                hit_d;
  miss_kind_e          kind_d;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // Field extraction. Out-of-range register values are clamped to the maximum.
  always_comb begin
    ob_eff    = (offset_bits_q > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : offset_bits_q;
    ib_eff    = (index_bits_q > INDEX_BITS_MAX) ? INDEX_BITS_MAX : index_bits_q;
    tag_shift = SHIFT_W'(ob_eff) + SHIFT_W'(ib_eff);
    addr_sh   = address_i >> ob_eff;
    idx_mask  = ~({LINE_W{1'b1}} << ib_eff);
    idx_d     = addr_sh[LINE_W-1:0] & idx_mask;
    tag_d     = address_i >> tag_shift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OFFSET_BITS_RESET;
      index_bits_q  <= INDEX_BITS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_OFFSET_BITS: offset_bits_q <= cfg_wdata_i[OFFSET_W-1:0];
        CFG_INDEX_BITS:  index_bits_q  <= cfg_wdata_i[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // The tag store is read at the accepting edge with the extracted index.
  dmc_tag_store u_tag_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_idx_i (idx_d),
    .rd_o     (rd),
    .wr_i     (wr)
  );

  // Classification of the looked-up line and the refill on a miss.
  always_comb begin
    hit_d = rd.valid && (rd.tag == tag_q);
    if (!rd.valid) begin
      kind_d = KIND_COMPULSORY;
    end else if (hit_d) begin
      kind_d = KIND_HIT;
    end else begin
      kind_d = KIND_CONFLICT;
    end
    wr.en  = busy_q && !hit_d;
    wr.idx = idx_q;
    wr.tag = tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      done_q     <= 1'b0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (busy_q) begin
        if (hit_d) begin
          if (hit_cnt_q != '1) begin
            hit_cnt_q <= hit_cnt_q + 1'b1;
          end
        end else if (miss_cnt_q != '1) begin
          miss_cnt_q <= miss_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= idx_d;
      tag_q <= tag_d;
    end
    if (busy_q) begin
      hit_q     <= hit_d;
      kind_q    <= kind_d;
      evicted_q <= (kind_d == KIND_CONFLICT);
      res_idx_q <= idx_q;
      res_tag_q <= tag_q;
    end
  end

  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign miss_kind_o  = kind_q;
  assign evicted_o    = evicted_q;
  assign line_index_o = res_idx_q;
  assign tag_value_o  = res_tag_q;
  assign hit_total_o  = hit_cnt_q;
  assign miss_total_o = miss_cnt_q;

  // Every result is preceded by a lookup.
  `ASSERT_PROP(a_done_after_lookup, clk_i, rst_ni, done_q |-> $past(busy_q))
  // The lookup lasts a single cycle, so busy never stays high longer.
  `ASSERT_PROP(a_lookup_one_cycle, clk_i, rst_ni, busy_q |=> !busy_q)
  // A hit reports the hit code and never an eviction.
  `ASSERT_NEVER(a_hit_consistent, clk_i, rst_ni,
                done_q && hit_q && (evicted_q || kind_q != KIND_HIT))
  // An eviction only comes with a conflict miss.
  `ASSERT_NEVER(a_evict_conflict, clk_i, rst_ni,
                done_q && (evicted_q != (kind_q == KIND_CONFLICT)))
  // The hit total moves only at the edge that produces a hit result.
  `ASSERT_PROP(a_hit_cnt_moves, clk_i, rst_ni,
               (hit_cnt_q != $past(hit_cnt_q)) |-> (done_q && hit_q))

endmodule

// ----- verif/tb_direct_mapped_cache_tag_check.sv -----
// Self-checking testbench for the direct-mapped cache tag check block.
// Depends on dmc_pkg and direct_mapped_cache_tag_check; needs no other file.
// A local predictor keeps its own tag memory and totals, and every result is checked.
module tb_direct_mapped_cache_tag_check;
  import dmc_pkg::*;

  // One expected lookup outcome, field for field as the block reports it.
  typedef struct {
    logic              hit;
    miss_kind_e        kind;
    logic              evicted;
    logic [LINE_W-1:0] line;
    logic [ADDR_W-1:0] tag;
    logic [ADDR_W-1:0] hits;
    logic [ADDR_W-1:0] misses;
  } lookup_t;

  // All block inputs start at known values; reset is asserted from time zero.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic                  cfg_idx_i   = CFG_OFFSET_BITS;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  start       = 1'b0;
  logic [ADDR_W-1:0]     address_i   = '0;

  logic                  busy;
  logic                  done_o;
  logic                  hit_o;
  logic [1:0]            miss_kind_o;
  logic                  evicted_o;
  logic [LINE_W-1:0]     line_index_o;
  logic [ADDR_W-1:0]     tag_value_o;
  logic [ADDR_W-1:0]     hit_total_o;
  logic [ADDR_W-1:0]     miss_total_o;

  direct_mapped_cache_tag_check u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start        (start),
    .busy         (busy),
    .address_i    (address_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .miss_kind_o  (miss_kind_o),
    .evicted_o    (evicted_o),
    .line_index_o (line_index_o),
    .tag_value_o  (tag_value_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the configuration registers, updated whenever the test writes one.
  logic [OFFSET_W-1:0] offset_cfg = OFFSET_BITS_RESET;
  logic [INDEX_W-1:0]  index_cfg  = INDEX_BITS_RESET;

  // Predicted cache state: valid bits, stored tags and the two running totals.
  logic              line_valid_m [MAX_LINES];
  logic [ADDR_W-1:0] line_tag_m   [MAX_LINES];
  logic [ADDR_W-1:0] hit_count_m  = '0;
  logic [ADDR_W-1:0] miss_count_m = '0;

  logic [ADDR_W-1:0] addr_q   [$];   // addresses waiting to be issued
  lookup_t           lookup_q [$];   // outcomes of accepted transactions, oldest first
  int                sender_idle_pct = 0;
  int                err_cnt = 0;
  bit                took = 1'b0;    // the last rising edge accepted a transaction

  initial begin
    foreach (line_valid_m[i]) begin
      line_valid_m[i] = 1'b0;
      line_tag_m[i]   = '0;
    end
  end

  // Effective field widths: register values beyond the legal range are clamped
  // the same way the block clamps them.
  function automatic int unsigned eff_offset();
    return (offset_cfg > OFFSET_BITS_MAX) ? OFFSET_BITS_MAX : offset_cfg;
  endfunction

  function automatic int unsigned eff_index();
    return (index_cfg > INDEX_BITS_MAX) ? INDEX_BITS_MAX : index_cfg;
  endfunction

  // Looks one address up in the predicted cache, refills on a miss and bumps
  // the saturating totals. The index never exceeds 63 since the index width
  // is clamped to 6, so the line slot is the index itself.
  function automatic lookup_t lookup_address(input logic [ADDR_W-1:0] addr);
    lookup_t           res;
    int unsigned       ob;
    int unsigned       ib;
    logic [ADDR_W-1:0] idx;
    logic [ADDR_W-1:0] tag;
    ob  = eff_offset();
    ib  = eff_index();
    idx = (addr >> ob) & ((32'd1 << ib) - 32'd1);
    tag = addr >> (ob + ib);
    res.hit     = 1'b0;
    res.evicted = 1'b0;
    res.line    = idx[LINE_W-1:0];
    res.tag     = tag;
    if (!line_valid_m[idx[LINE_W-1:0]]) begin
      res.kind = KIND_COMPULSORY;
    end else if (line_tag_m[idx[LINE_W-1:0]] == tag) begin
      res.kind = KIND_HIT;
      res.hit  = 1'b1;
    end else begin
      res.kind    = KIND_CONFLICT;
      res.evicted = 1'b1;
    end
    if (res.hit) begin
      if (hit_count_m != '1) hit_count_m = hit_count_m + 1;
    end else begin
      if (miss_count_m != '1) miss_count_m = miss_count_m + 1;
      line_valid_m[idx[LINE_W-1:0]] = 1'b1;
      line_tag_m[idx[LINE_W-1:0]]   = tag;
    end
    res.hits   = hit_count_m;
    res.misses = miss_count_m;
    return res;
  endfunction

  task automatic report_field(input string fld, input logic [ADDR_W-1:0] exp_v,
                              input logic [ADDR_W-1:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, fld, exp_v, act_v);
    end
  endtask

  // Acceptance tracking and result checking, both at the rising edge. The
  // block's outputs change by nonblocking updates, so the values read here are
  // the ones from before the edge. A result is compared before the outcome of
  // a transaction accepted at the same edge is queued; the result always
  // belongs to an earlier transaction anyway.
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (lookup_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with no transaction outstanding, tag 0x%08h",
                   $time, tag_value_o);
        end else begin
          want = lookup_q.pop_front();
          report_field("hit",        want.hit,     hit_o);
          report_field("miss_kind",  want.kind,    miss_kind_o);
          report_field("evicted",    want.evicted, evicted_o);
          report_field("line_index", want.line,    line_index_o);
          report_field("tag_value",  want.tag,     tag_value_o);
          report_field("hit_total",  want.hits,    hit_total_o);
          report_field("miss_total", want.misses,  miss_total_o);
        end
      end
      took = start && !busy;
      if (took) lookup_q.push_back(lookup_address(address_i));
    end
  end

  // Driver: at the falling edge, once the transaction on the port has been
  // taken (or nothing is offered), either present the next address or go idle
  // for this cycle. A held start gets exactly one assignment per edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || took)) begin
      if (addr_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start     <= 1'b1;
        address_i <= addr_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Waits until every queued address has been issued and every result has
  // come back, then lets the clock run on so the block is surely idle.
  task automatic drain();
    while (addr_q.size() != 0 || start || lookup_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one configuration register while the block is idle.
  task automatic write_cfg(input cfg_reg_e which, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= which;
    cfg_wdata_i <= data;
    if (which == CFG_OFFSET_BITS) offset_cfg = data;
    else                          index_cfg  = data[INDEX_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Builds an address from a small pool of tags so that hits, compulsory
  // misses and conflict misses all occur often; one in six is fully random
  // so every address bit toggles.
  function automatic logic [ADDR_W-1:0] pick_address(input logic [ADDR_W-1:0] tags[4]);
    int unsigned       ob;
    int unsigned       ib;
    logic [ADDR_W-1:0] idx;
    logic [ADDR_W-1:0] off;
    ob = eff_offset();
    ib = eff_index();
    if ($urandom_range(5) == 0) return $urandom;
    idx = $urandom_range((1 << ib) - 1);
    off = $urandom & ((32'd1 << ob) - 32'd1);
    return (tags[$urandom_range(3)] << (ob + ib)) | (idx << ob) | off;
  endfunction

  // Register settings per phase: both zero, both at the maximum, values past
  // the maximum that get clamped, and a few in between. An index write with
  // the top data bit set checks that only the low three bits count.
  localparam int NUM_SETTINGS = 10;
  localparam logic [CFG_DATA_W-1:0] OFFSET_SET [NUM_SETTINGS] =
    '{4'd0, 4'd12, 4'd15, 4'd13, 4'd0, 4'd12, 4'd1, 4'd2, 4'd7, 4'd4};
  localparam logic [CFG_DATA_W-1:0] INDEX_SET [NUM_SETTINGS] =
    '{4'd0, 4'd6, 4'd7, 4'hE, 4'd6, 4'd0, 4'd1, 4'd5, 4'h9, 4'd3};

  initial begin
    logic [ADDR_W-1:0] tags [4];
    int                idle_mix [4];
    idle_mix = '{0, 50, 0, 33};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset configuration (4 offset bits, 3 index
    // bits): first touch of a line, repeat hit, offset bits ignored on a hit,
    // conflicts that evict and refill, and the all-ones and all-zeros extremes.
    addr_q = '{32'h0000_0000, 32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF,
               32'hFFFF_FFF0, 32'h0000_0080, 32'h0000_0000, 32'h8000_0000,
               32'h8000_0008, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
               32'hAAAA_AAA0, 32'h5555_555F, 32'h0000_0070, 32'h0000_0010,
               32'h0000_0010, 32'hFFFF_FF8F, 32'h7FFF_FFF0, 32'h0000_0080};
    drain();

    for (int s = 0; s < NUM_SETTINGS + 3; s++) begin
      if (s < NUM_SETTINGS) begin
        write_cfg(CFG_OFFSET_BITS, OFFSET_SET[s]);
        write_cfg(CFG_INDEX_BITS,  INDEX_SET[s]);
      end else begin
        write_cfg(CFG_OFFSET_BITS, $urandom);
        write_cfg(CFG_INDEX_BITS,  $urandom);
      end
      foreach (tags[t]) tags[t] = ($urandom_range(1) == 0) ? $urandom_range(3) : $urandom;
      sender_idle_pct = idle_mix[s % 4];
      repeat (70) addr_q.push_back(pick_address(tags));
      drain();
      sender_idle_pct = 0;
    end

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
